### rtl/core/fqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants for the handle queue with delete-by-value.
// ----------------------------------------------------------------------------
package fqd_pkg;

	localparam int DEPTH   = 16;
	localparam int HND_W   = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);

	typedef enum logic [1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1,
		CMD_DEL = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NULL     = 3'd4
	} status_t;

	typedef logic [HND_W-1:0] handle_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] idx_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic    enq_en;   // write handle at the tail slot
		logic    deq_en;   // every cell takes its right neighbour
		logic    del_en;   // cells at or after the first match take neighbour
		handle_t handle;
		count_t  count;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/fqd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
interface fqd_req_if;
	logic             valid;
	logic             ready;
	logic [1:0]       command;
	fqd_pkg::handle_t handle;

	modport source (output valid, command, handle, input ready);
	modport sink   (input valid, command, handle, output ready);
endinterface

interface fqd_rsp_if;
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	fqd_pkg::handle_t handle_out;
	fqd_pkg::count_t  count;

	modport source (output valid, status, handle_out, count, input ready);
	modport sink   (input valid, status, handle_out, count, output ready);
endinterface

`default_nettype wire

### rtl/core/fifo_queue_with_delete_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_core
// Bounded ordered queue of nonzero handles with enqueue, dequeue and delete of
// the first matching handle, built as a row of shifting compare cells.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after command acceptance.
// Throughput: one item per cycle if rsp is ready; all cells compare and shift.
// Reset: arst_n clears occupancy and the result valid flag; slot contents and
// the result payload are left as they are and only read once written.
module fifo_queue_with_delete_core (
	input  wire        clk,
	input  wire        arst_n,
	fqd_req_if.sink    req,
	fqd_rsp_if.source  rsp
);
	import fqd_pkg::*;

	count_t     occ_q;
	count_t     occ_nxt;
	logic       rsp_valid_q;
	status_t    status_q;
	handle_t    hout_q;
	count_t     rcount_q;

	logic       acc;
	cmd_t       cmd;
	logic       h_null;
	logic       empty;
	logic       full;
	logic       found;
	status_t    status_nxt;
	handle_t    hout_nxt;
	cell_ctrl_t ctrl;

	handle_t    cell_data  [DEPTH];
	logic       cell_found [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign cmd       = cmd_t'(req.command);
	assign h_null    = (req.handle == '0);
	assign empty     = (occ_q == '0);
	assign full      = (occ_q == CNT_W'(DEPTH));
	assign found     = cell_found[DEPTH-1];

	always_comb begin
		ctrl.handle = req.handle;
		ctrl.count  = occ_q;
		ctrl.enq_en = acc && (cmd == CMD_ENQ) && !h_null && !full;
		ctrl.deq_en = acc && (cmd == CMD_DEQ) && !empty;
		ctrl.del_en = acc && (cmd == CMD_DEL) && !h_null && !empty;
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			handle_t nbr;
			logic    fin;
			if (g == DEPTH - 1) begin : g_last
				assign nbr = '0;
			end else begin : g_mid
				assign nbr = cell_data[g+1];
			end
			if (g == 0) begin : g_head
				assign fin = 1'b0;
			end else begin : g_body
				assign fin = cell_found[g-1];
			end
			fqd_cell u_cell (
				.clk       (clk),
				.idx       (IDX_W'(g)),
				.ctrl      (ctrl),
				.nbr_data  (nbr),
				.found_in  (fin),
				.data      (cell_data[g]),
				.found_out (cell_found[g])
			);
		end
	endgenerate

	always_comb begin
		status_nxt = ST_OK;
		hout_nxt   = '0;
		occ_nxt    = occ_q;
		unique case (cmd)
			CMD_ENQ: begin
				if (h_null)    status_nxt = ST_NULL;
				else if (full) status_nxt = ST_FULL;
				else           occ_nxt    = occ_q + 1'b1;
			end
			CMD_DEQ: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					hout_nxt = cell_data[0];
					occ_nxt  = occ_q - 1'b1;
				end
			end
			CMD_DEL: begin
				if (h_null)      status_nxt = ST_NULL;
				else if (empty)  status_nxt = ST_EMPTY;
				else if (!found) status_nxt = ST_NOTFOUND;
				else             occ_nxt    = occ_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				occ_q       <= occ_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_nxt;
			hout_q   <= hout_nxt;
			rcount_q <= occ_nxt;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.handle_out = hout_q;
	assign rsp.count      = rcount_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond depth");

	a_rcount: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (rcount_q == occ_q))
		else $error("reported count differs from occupancy");

	a_enq_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq_en |=> (occ_q == $past(occ_q) + 1'b1))
		else $error("enqueue did not grow the queue");

	a_notfound_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.del_en && !found) |=> (occ_q == $past(occ_q)))
		else $error("failed delete changed occupancy");

endmodule

`default_nettype wire

### rtl/core/fqd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_cell
// One queue slot: holds a handle, compares it against the broadcast handle
// and shifts toward the head when a dequeue or delete closes a gap.
// ----------------------------------------------------------------------------
module fqd_cell (
	input  wire                  clk,
	input  wire fqd_pkg::idx_t   idx,
	input  wire fqd_pkg::cell_ctrl_t ctrl,
	input  wire fqd_pkg::handle_t nbr_data,
	input  wire                  found_in,
	output fqd_pkg::handle_t     data,
	output logic                 found_out
);
	import fqd_pkg::*;

	handle_t data_q;
	logic    slot_valid;
	logic    match;

	assign slot_valid = count_t'(idx) < ctrl.count;
	assign match      = slot_valid && (data_q == ctrl.handle);
	assign found_out  = found_in | match;
	assign data       = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq_en && (count_t'(idx) == ctrl.count)) begin
			data_q <= ctrl.handle;
		end else if (ctrl.deq_en || (ctrl.del_en && found_out)) begin
			data_q <= nbr_data;
		end
	end

endmodule

`default_nettype wire
